// ===== design/rmag_pkg.sv =====
// ---------------------------------------------------------------------------
// rmag_pkg: shared types and constants of the row-major address generator
// Item and result structs, item kind codes, controller-to-datapath command
// and status structs, and the parameter defaults.
// ---------------------------------------------------------------------------
package rmag_pkg;

   localparam int NUM_ARRAYS_DEFAULT = 8;
   localparam int MAX_DIMS_DEFAULT   = 8;

   // width of dimension counts inside the block: holds a count up to 31
   localparam int CNT_W = 5;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_BOUNDS = 2'd1;
   localparam logic [1:0] KIND_INDEX  = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         array_id;
      logic [2:0]         dim_index;
      logic signed [31:0] base;
      logic [30:0]        elem_size;
      logic [3:0]         dim_count;
      logic signed [31:0] lower;
      logic signed [31:0] upper;
      logic signed [31:0] index;
   } rmag_req_type;

   typedef struct packed {
      logic [2:0]         array_id_res;
      logic signed [63:0] address;
   } rmag_rsp_type;

   // step of the shared 32x32 multiplier sequence
   typedef enum logic [2:0] {
      MUL_IDLE,
      MUL_LL,
      MUL_LH,
      MUL_HL,
      MUL_FINISH
   } rmag_mul_type;

   typedef struct packed {
      logic         capture;
      logic         hdr_read;
      logic         dim_read;
      rmag_mul_type mul_step;
      logic         scale;
      logic         accumulate;
      logic         emit;
   } rmag_cmd_type;

   typedef struct packed {
      logic index_item;
      logic last;
   } rmag_stat_type;

endpackage

// ===== design/rmag_datapath.sv =====
// ---------------------------------------------------------------------------
// rmag_datapath: descriptor tables, horner accumulator and multiplier
// Holds the header and bounds memories, the position counter, the offset
// accumulator and one shared 32x32 multiplier used over four steps for
// each 64-bit product, both for the horner step and the final scaling.
// ---------------------------------------------------------------------------
module rmag_datapath
   import rmag_pkg::*;
#(
   parameter int NUM_ARRAYS = NUM_ARRAYS_DEFAULT,
   parameter int MAX_DIMS   = MAX_DIMS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  rmag_req_type  req_item,
   input  rmag_cmd_type  cmd,
   output rmag_stat_type stat,
   output logic          rsp_strobe,
   output rmag_rsp_type  rsp_item
);

   localparam int AID_W  = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
   localparam int POS_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int SLOTS  = NUM_ARRAYS * MAX_DIMS;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef struct packed {
      logic [31:0] base;
      logic [30:0] size;
      logic [3:0]  dims;
   } hdr_entry_type;

   // extent runs up to 2^32, so it needs two bits above the bounds
   typedef struct packed {
      logic [31:0] lower;
      logic [33:0] extent;
   } dim_entry_type;

   hdr_entry_type hdr_mem [NUM_ARRAYS];
   dim_entry_type dim_mem [SLOTS];

   rmag_req_type  req_ff;
   hdr_entry_type hdr_rd_ff;
   dim_entry_type dim_rd_ff;
   logic          last_ff;
   logic [POS_W-1:0] pos_eff_ff;
   logic [POS_W-1:0] pos_ff;
   logic [63:0]   acc_ff;
   logic [63:0]   prod_ff;
   logic [63:0]   sum_ff;
   logic [63:0]   diff_ff;
   logic          rsp_valid_ff;
   rmag_rsp_type  rsp_ff;

   logic             id_ok;
   logic             dim_ok;
   logic [SLOT_W-1:0] wr_slot;
   logic [SLOT_W-1:0] rd_slot;
   logic [CNT_W-1:0] dims_eff;
   logic [CNT_W-1:0] pos_eff;
   logic             last_in;
   logic [63:0]      op_b;
   logic [63:0]      addend;
   logic [31:0]      mul_x;
   logic [31:0]      mul_y;
   logic [63:0]      mul_p;
   logic [63:0]      result;
   logic [63:0]      diff_in;

   assign id_ok  = (9'(req_item.array_id) < 9'(NUM_ARRAYS));
   assign dim_ok = (CNT_W'(req_item.dim_index) < CNT_W'(MAX_DIMS));

   assign stat.index_item = id_ok && (req_item.kind == KIND_INDEX);
   assign stat.last       = last_ff;

   assign wr_slot = SLOT_W'(req_item.array_id) * SLOT_W'(MAX_DIMS)
                  + SLOT_W'(req_item.dim_index);

   // effective dimension count and component position of the access
   always_comb begin
      dims_eff = {1'b0, hdr_rd_ff.dims};
      if (dims_eff == '0) begin
         dims_eff = CNT_W'(1);
      end
      if (dims_eff > CNT_W'(MAX_DIMS)) begin
         dims_eff = CNT_W'(MAX_DIMS);
      end
      pos_eff = CNT_W'(pos_ff);
      if (pos_eff >= dims_eff) begin
         pos_eff = dims_eff - CNT_W'(1);
      end
      last_in = (pos_eff == dims_eff - CNT_W'(1));
   end

   assign rd_slot = SLOT_W'(req_ff.array_id) * SLOT_W'(MAX_DIMS)
                  + SLOT_W'(pos_eff);

   // table writes on definition transfers
   always_ff @(posedge clock) begin
      if (cmd.capture && id_ok) begin
         if (req_item.kind == KIND_HEADER) begin
            hdr_mem[AID_W'(req_item.array_id)] <= '{base: req_item.base,
                                                    size: req_item.elem_size,
                                                    dims: req_item.dim_count};
         end
         if (req_item.kind == KIND_BOUNDS && dim_ok) begin
            dim_mem[wr_slot] <= '{lower:  req_item.lower,
                                  extent: {{2{req_item.upper[31]}}, req_item.upper}
                                        - {{2{req_item.lower[31]}}, req_item.lower}
                                        + 34'd1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hdr_read) begin
         hdr_rd_ff <= hdr_mem[AID_W'(req_ff.array_id)];
      end
      if (cmd.dim_read) begin
         dim_rd_ff <= dim_mem[rd_slot];
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      if (cmd.scale) begin
         op_b   = {33'b0, hdr_rd_ff.size};
         addend = {{32{hdr_rd_ff.base[31]}}, hdr_rd_ff.base};
      end else begin
         op_b   = {{30{dim_rd_ff.extent[33]}}, dim_rd_ff.extent};
         addend = diff_ff;
      end
      unique case (cmd.mul_step)
         MUL_LH: begin
            mul_x = acc_ff[31:0];
            mul_y = op_b[63:32];
         end
         MUL_HL: begin
            mul_x = acc_ff[63:32];
            mul_y = op_b[31:0];
         end
         default: begin
            mul_x = acc_ff[31:0];
            mul_y = op_b[31:0];
         end
      endcase
   end

   assign mul_p   = {32'b0, mul_x} * {32'b0, mul_y};
   assign result  = sum_ff + {prod_ff[31:0], 32'b0};
   assign diff_in = {{32{req_ff.index[31]}}, req_ff.index}
                  - {{32{dim_rd_ff.lower[31]}}, dim_rd_ff.lower};

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.dim_read) begin
         last_ff    <= last_in;
         pos_eff_ff <= POS_W'(pos_eff);
      end
      unique case (cmd.mul_step)
         MUL_LL: begin
            prod_ff <= mul_p;
            diff_ff <= diff_in;
         end
         MUL_LH: begin
            sum_ff  <= prod_ff + addend;
            prod_ff <= mul_p;
         end
         MUL_HL: begin
            sum_ff  <= result;
            prod_ff <= mul_p;
         end
         default: begin
         end
      endcase
      if (cmd.emit) begin
         rsp_ff.array_id_res <= req_ff.array_id;
         rsp_ff.address      <= result;
      end
   end

   // control state: position, accumulator, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
         if (cmd.accumulate) begin
            acc_ff <= result;
            pos_ff <= last_ff ? '0 : pos_eff_ff + POS_W'(1);
         end
         if (cmd.emit) begin
            acc_ff <= '0;
         end
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== design/rmag_controller.sv =====
// ---------------------------------------------------------------------------
// rmag_controller: sequencer of the row-major address generator
// Steps an index component through header read, bounds read and the four
// multiplier steps of the horner update, then the four steps of the final
// scaling when the component closes the access.
// ---------------------------------------------------------------------------
module rmag_controller
   import rmag_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  rmag_stat_type stat,
   output rmag_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR,
      ST_DIM,
      ST_H0,
      ST_H1,
      ST_H2,
      ST_H3,
      ST_S0,
      ST_S1,
      ST_S2,
      ST_S3
   } state_type;

   state_type state_ff;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && stat.index_item) begin
                  state_ff <= ST_HDR;
               end
            end
            ST_HDR: state_ff <= ST_DIM;
            ST_DIM: state_ff <= ST_H0;
            ST_H0:  state_ff <= ST_H1;
            ST_H1:  state_ff <= ST_H2;
            ST_H2:  state_ff <= ST_H3;
            ST_H3:  state_ff <= stat.last ? ST_S0 : ST_IDLE;
            ST_S0:  state_ff <= ST_S1;
            ST_S1:  state_ff <= ST_S2;
            ST_S2:  state_ff <= ST_S3;
            ST_S3:  state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.mul_step   = MUL_IDLE;
      cmd.capture    = accept;
      cmd.hdr_read   = (state_ff == ST_HDR);
      cmd.dim_read   = (state_ff == ST_DIM);
      cmd.scale      = (state_ff == ST_S0) || (state_ff == ST_S1)
                    || (state_ff == ST_S2) || (state_ff == ST_S3);
      cmd.accumulate = (state_ff == ST_H3);
      cmd.emit       = (state_ff == ST_S3);
      unique case (state_ff)
         ST_H0, ST_S0: cmd.mul_step = MUL_LL;
         ST_H1, ST_S1: cmd.mul_step = MUL_LH;
         ST_H2, ST_S2: cmd.mul_step = MUL_HL;
         ST_H3, ST_S3: cmd.mul_step = MUL_FINISH;
         default:      cmd.mul_step = MUL_IDLE;
      endcase
   end

endmodule

// ===== design/row_major_address_generator_core.sv =====
// ---------------------------------------------------------------------------
// row_major_address_generator_core: row-major array address generator
// Keeps array descriptors, folds index components into a row-major offset
// one at a time and reports base plus element size times offset.
//
//   channel   ports                       transfer
//   input     start, busy, req_item       start high while busy low
//   result    rsp_strobe, rsp_item        every cycle rsp_strobe is high
//
// a definition item is taken at its transfer; an index component keeps busy
// high after its transfer for header read, bounds read and four steps of the
// shared 32x32 multiplier
// the last component of an access adds four more multiplier steps for the
// scaling by element size, the result strobe coming in the
// first idle cycle after
// reset clears position, accumulator, result strobe and state; tables are
// undefined until written, and results cannot be held off by the receiver
// ---------------------------------------------------------------------------
module row_major_address_generator_core
   import rmag_pkg::*;
#(
   parameter int NUM_ARRAYS = NUM_ARRAYS_DEFAULT,
   parameter int MAX_DIMS   = MAX_DIMS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  rmag_req_type req_item,
   output logic         rsp_strobe,
   output rmag_rsp_type rsp_item
);

   rmag_cmd_type  cmd;
   rmag_stat_type stat;

   rmag_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rmag_datapath #(
      .NUM_ARRAYS (NUM_ARRAYS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== tb/row_major_address_generator_core_checker.sv =====
// ---------------------------------------------------------------------------
// row_major_address_generator_core_checker: address predictor and scoreboard
// Watches the item and result channels of the address generator, keeps its
// own copy of the descriptor tables and the Horner accumulator, predicts the
// element address of every finished access and compares each result strobe,
// field by field, against the oldest predicted address.
// ---------------------------------------------------------------------------
module row_major_address_generator_core_checker
   import rmag_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  rmag_req_type req_item,
   input  logic         rsp_strobe,
   input  rmag_rsp_type rsp_item,
   output int           fail_count,
   output int           outstanding,
   output int           addresses_checked
);

   localparam int ARRAYS = NUM_ARRAYS_DEFAULT;
   localparam int DIMS   = MAX_DIMS_DEFAULT;

   logic [31:0]  base_of   [ARRAYS];
   logic [30:0]  size_of   [ARRAYS];
   logic [3:0]   count_of  [ARRAYS];
   logic [31:0]  lower_of  [ARRAYS*DIMS];
   logic [63:0]  extent_of [ARRAYS*DIMS];
   int unsigned  position;
   logic [63:0]  offset_acc;
   rmag_rsp_type pending_addresses [$];

   function automatic logic [63:0] widen(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   // one accepted transfer: update descriptors or fold an index component
   task automatic fold_transfer(input rmag_req_type it);
      int unsigned  a;
      int unsigned  dims;
      int unsigned  pos;
      int unsigned  slot;
      rmag_rsp_type want;
      a = {29'd0, it.array_id};
      case (it.kind)
         KIND_HEADER: begin
            base_of[a]  = it.base;
            size_of[a]  = it.elem_size;
            count_of[a] = it.dim_count;
         end
         KIND_BOUNDS: begin
            slot = a * DIMS + {29'd0, it.dim_index};
            lower_of[slot]  = it.lower;
            // extent kept at full width, may be negative for reversed bounds
            extent_of[slot] = widen(it.upper) - widen(it.lower) + 64'd1;
         end
         KIND_INDEX: begin
            dims = {28'd0, count_of[a]};
            if (dims == 0) dims = 1;
            if (dims > DIMS) dims = DIMS;
            pos  = (position >= dims) ? dims - 1 : position;
            slot = a * DIMS + pos;
            offset_acc = offset_acc * extent_of[slot]
                         + (widen(it.index) - widen(lower_of[slot]));
            if (pos + 1 >= dims) begin
               want.array_id_res = it.array_id;
               want.address      = widen(base_of[a]) + {33'd0, size_of[a]} * offset_acc;
               pending_addresses = {pending_addresses, want};
               position   = 0;
               offset_acc = '0;
            end else begin
               position = pos + 1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      rmag_rsp_type want;
      if (reset) begin
         position   = 0;
         offset_acc = '0;
         pending_addresses.delete();
         outstanding <= 0;
      end else begin
         // results never come at the edge of their own transfer, so compare first
         if (rsp_strobe) begin
            if (pending_addresses.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: array %0d address %h",
                           rsp_item.array_id_res, rsp_item.address);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_addresses.pop_front();
               addresses_checked <= addresses_checked + 1;
               if (rsp_item.array_id_res !== want.array_id_res ||
                   rsp_item.address !== want.address) begin
                  if (fail_count < 10) begin
                     $display("mismatch: array_id_res expected %0d got %0d",
                              want.array_id_res, rsp_item.array_id_res);
                     $display("          address      expected %h got %h",
                              want.address, rsp_item.address);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) fold_transfer(req_item);
         outstanding <= pending_addresses.size();
      end
   end

endmodule

// ===== tb/row_major_address_generator_core_tb.sv =====
// ---------------------------------------------------------------------------
// row_major_address_generator_core_tb: testbench of the address generator
// Drives header, bounds and index transfers with random gaps, first a short
// directed run over the field extremes and the corner cases of dimension
// handling, then random accesses with interleaved definitions and noise.
// Checking is left to the checker instance, which reports a failure count.
// ---------------------------------------------------------------------------
module row_major_address_generator_core_tb;
   import rmag_pkg::*;

   localparam int          ARRAYS       = NUM_ARRAYS_DEFAULT;
   localparam int          DIMS         = MAX_DIMS_DEFAULT;
   localparam int          ITEM_TARGET  = 1050;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 20;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   rmag_req_type req_item = '0;
   logic         busy;
   logic         rsp_strobe;
   rmag_rsp_type rsp_item;
   int           fail_count;
   int           outstanding;
   int           addresses_checked;
   int           cycle_count = 0;

   // what the stimulus knows of the block, so no unwritten entry is ever read
   bit           hdr_ok [ARRAYS];
   bit           dim_ok [ARRAYS*DIMS];
   logic [3:0]   count_sh [ARRAYS];
   int unsigned  position_sh = 0;
   bit           steady = 1'b0;
   int           items_sent = 0;
   int           components_sent = 0;

   always #10 clock = ~clock;

   row_major_address_generator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   row_major_address_generator_core_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_item          (req_item),
      .rsp_strobe        (rsp_strobe),
      .rsp_item          (rsp_item),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .addresses_checked (addresses_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d addresses still due", cycle_count, outstanding);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int unsigned effective_count(input int unsigned a);
      int unsigned n;
      n = {28'd0, count_sh[a]};
      if (n == 0) n = 1;
      if (n > DIMS) n = DIMS;
      return n;
   endfunction

   function automatic int unsigned next_dim(input int unsigned a);
      int unsigned n;
      n = effective_count(a);
      return (position_sh >= n) ? n - 1 : position_sh;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'd0;
         3:       return 32'hffff_ffff;
         4, 5:    return $urandom_range(0, 200) - 100;
         default: return $urandom;
      endcase
   endfunction

   // fields that the kind does not use are random too
   function automatic rmag_req_type random_item();
      rmag_req_type it;
      it.kind      = 2'($urandom_range(0, 3));
      it.array_id  = 3'($urandom);
      it.dim_index = 3'($urandom);
      it.base      = $urandom;
      it.elem_size = 31'($urandom);
      it.dim_count = 4'($urandom);
      it.lower     = $urandom;
      it.upper     = $urandom;
      it.index     = $urandom;
      return it;
   endfunction

   function automatic rmag_req_type make_header(input logic [2:0] a, input logic [31:0] b,
                                                input logic [30:0] s, input logic [3:0] n);
      rmag_req_type it;
      it           = random_item();
      it.kind      = KIND_HEADER;
      it.array_id  = a;
      it.base      = b;
      it.elem_size = s;
      it.dim_count = n;
      return it;
   endfunction

   function automatic rmag_req_type make_bounds(input logic [2:0] a, input logic [2:0] d,
                                                input logic [31:0] lo, input logic [31:0] hi);
      rmag_req_type it;
      it           = random_item();
      it.kind      = KIND_BOUNDS;
      it.array_id  = a;
      it.dim_index = d;
      it.lower     = lo;
      it.upper     = hi;
      return it;
   endfunction

   function automatic rmag_req_type make_index(input logic [2:0] a, input logic [31:0] v);
      rmag_req_type it;
      it          = random_item();
      it.kind     = KIND_INDEX;
      it.array_id = a;
      it.index    = v;
      return it;
   endfunction

   task automatic transfer_item(input rmag_req_type it);
      int          gap;
      int unsigned a;
      int unsigned pos;
      if ($urandom_range(0, 39) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      // busy is settled by the falling edge, so the next rising edge accepts
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      a = {29'd0, it.array_id};
      case (it.kind)
         KIND_HEADER: begin
            hdr_ok[a]   = 1'b1;
            count_sh[a] = it.dim_count;
            items_sent++;
         end
         KIND_BOUNDS: begin
            dim_ok[a * DIMS + {29'd0, it.dim_index}] = 1'b1;
            items_sent++;
         end
         KIND_INDEX: begin
            pos = next_dim(a);
            position_sh = (pos + 1 >= effective_count(a)) ? 0 : pos + 1;
            items_sent++;
            components_sent++;
         end
         default: ;
      endcase
   endtask

   task automatic random_header(input int unsigned a);
      logic [30:0] s;
      logic [3:0]  n;
      case ($urandom_range(0, 5))
         0:       s = '0;
         1:       s = '1;
         2, 3:    s = 31'($urandom_range(1, 16));
         default: s = 31'($urandom);
      endcase
      // mostly short shapes, now and then any count including zero and over range
      n = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4));
      transfer_item(make_header(3'(a), pick_word(), s, n));
   endtask

   task automatic random_bounds(input int unsigned a, input int unsigned d);
      logic [31:0] lo;
      logic [31:0] hi;
      case ($urandom_range(0, 7))
         0: begin
            lo = pick_word();
            hi = pick_word();
         end
         1: begin
            lo = pick_word();
            hi = lo;
         end
         default: begin
            lo = $urandom_range(0, 16) - 8;
            hi = lo + $urandom_range(0, 9);
         end
      endcase
      transfer_item(make_bounds(3'(a), 3'(d), lo, hi));
   endtask

   task automatic random_index(input int unsigned a);
      logic [31:0] v;
      v = ($urandom_range(0, 5) == 0) ? pick_word() : $urandom_range(0, 30) - 10;
      transfer_item(make_index(3'(a), v));
   endtask

   // write whatever the next component of this array would read
   task automatic prepare(input int unsigned a);
      if (!hdr_ok[a]) random_header(a);
      if (!dim_ok[a * DIMS + next_dim(a)]) random_bounds(a, next_dim(a));
   endtask

   initial begin : stimulus
      rmag_req_type noise;
      int unsigned  a;
      int unsigned  b;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // extremes: widest and reversed extents, largest size, wrapping address
      transfer_item(make_header(3'd0, 32'h8000_0000, 31'h7fff_ffff, 4'd2));
      transfer_item(make_bounds(3'd0, 3'd0, 32'h8000_0000, 32'h7fff_ffff));
      transfer_item(make_bounds(3'd0, 3'd1, 32'h7fff_ffff, 32'h8000_0000));
      transfer_item(make_index(3'd0, 32'h7fff_ffff));
      // unused kind in the middle of an access is ignored
      noise      = '1;
      noise.kind = KIND_UNUSED;
      transfer_item(noise);
      transfer_item(make_index(3'd0, 32'h8000_0000));
      // zero dimension count acts as one, zero element size
      transfer_item(make_header(3'd7, 32'h7fff_ffff, 31'd0, 4'd0));
      transfer_item(make_bounds(3'd7, 3'd0, 32'd0, 32'd0));
      transfer_item(make_index(3'd7, 32'hffff_ffff));
      // definition during an access, then a component past the other array's count
      transfer_item(make_index(3'd0, 32'd3));
      transfer_item(make_header(3'd3, 32'd100, 31'd4, 4'd1));
      transfer_item(make_bounds(3'd3, 3'd0, 32'd10, 32'd20));
      transfer_item(make_index(3'd3, 32'd15));
      // count above the dimension limit, last dimension slot
      transfer_item(make_header(3'd5, 32'hffff_ffff, 31'd1, 4'd15));
      transfer_item(make_bounds(3'd5, 3'd7, 32'h7fff_ffff, 32'h7fff_ffff));

      while (items_sent < ITEM_TARGET) begin
         a = $urandom_range(0, ARRAYS - 1);
         if (!hdr_ok[a] || $urandom_range(0, 3) == 0) random_header(a);
         for (int unsigned d = 0; d < effective_count(a); d++)
            if (!dim_ok[a * DIMS + d] || $urandom_range(0, 5) == 0) random_bounds(a, d);
         do begin
            // now and then something else lands between two components
            if ($urandom_range(0, 7) == 0) begin
               b = $urandom_range(0, ARRAYS - 1);
               case ($urandom_range(0, 3))
                  0: begin
                     noise      = random_item();
                     noise.kind = KIND_UNUSED;
                     transfer_item(noise);
                  end
                  1:       random_header(b);
                  2:       random_bounds(b, $urandom_range(0, DIMS - 1));
                  default: begin
                     prepare(b);
                     random_index(b);
                  end
               endcase
            end
            prepare(a);
            random_index(a);
         end while (position_sh != 0);
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d definition and index items, %0d of them index components",
               items_sent, components_sent);
      $display("checked %0d element addresses", addresses_checked);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
